/* hw/rtl/jssc_pkg.sv */
package jssc_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EXPECT       = 2'd1,
    ST_INVALID      = 2'd2,
    ST_NOT_SINGULAR = 2'd3
  } status_t;

  // Value type codes
  typedef enum logic [1:0] {
    TY_NULL   = 2'd0,
    TY_FALSE  = 2'd1,
    TY_TRUE   = 2'd2,
    TY_NUMBER = 2'd3
  } vtype_t;

  // Parser phases; codes 12..15 are unused
  typedef enum logic [3:0] {
    PH_LEAD       = 4'd0,
    PH_LIT        = 4'd1,
    PH_SIGN       = 4'd2,
    PH_ZERO       = 4'd3,
    PH_INT        = 4'd4,
    PH_FRAC_FIRST = 4'd5,
    PH_FRAC       = 4'd6,
    PH_EXP_MARK   = 4'd7,
    PH_EXP_FIRST  = 4'd8,
    PH_EXP        = 4'd9,
    PH_TRAIL      = 4'd10,
    PH_ERR        = 4'd11
  } phase_t;

  // Literal selector
  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_TRUE  = 2'd2;

  localparam logic [7:0] CH_TERM = 8'h00;

  // Result handed from the parser to the output register
  typedef struct packed {
    status_t status;
    vtype_t  vtype;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Expected byte of a literal at a given position
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      LIT_FALSE: begin
        case (p)
          3'd0:    c = "f";
          3'd1:    c = "a";
          3'd2:    c = "l";
          3'd3:    c = "s";
          default: c = "e";
        endcase
      end
      LIT_TRUE: begin
        case (p)
          3'd0:    c = "t";
          3'd1:    c = "r";
          3'd2:    c = "u";
          3'd3:    c = "e";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (p)
          3'd0:    c = "n";
          3'd1:    c = "u";
          3'd2:    c = "l";
          3'd3:    c = "l";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

/* hw/rtl/jssc_parse.sv */
// Parser state and per-byte transition; a result comes out on the terminator
module jssc_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,      // consume ch this cycle
  input  logic [7:0]           ch,
  output jssc_pkg::result_t    result,    // valid when step and ch is the terminator
  output jssc_pkg::phase_t     phase      // current phase, for checks
);

  jssc_pkg::phase_t   phase_r, phase_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [2:0]         pos_r, pos_nxt;
  jssc_pkg::status_t  hstat_r, hstat_nxt;
  jssc_pkg::vtype_t   htype_r, htype_nxt;

  logic [1:0] k;
  logic [2:0] p;
  logic [2:0] p_inc;

  assign phase = phase_r;

  // clamp literal indexes as the spec does for unreachable codes
  assign k     = (kind_r == 2'd3) ? jssc_pkg::LIT_NULL : kind_r;
  assign p     = (pos_r > 3'd4) ? 3'd4 : pos_r;
  assign p_inc = p + 3'd1;

  // terminator result
  always_comb begin
    result.status = jssc_pkg::ST_INVALID;
    case (phase_r)
      jssc_pkg::PH_LEAD:  result.status = jssc_pkg::ST_EXPECT;
      jssc_pkg::PH_ZERO,
      jssc_pkg::PH_INT,
      jssc_pkg::PH_FRAC,
      jssc_pkg::PH_EXP,
      jssc_pkg::PH_TRAIL: result.status = jssc_pkg::ST_OK;
      jssc_pkg::PH_ERR:   result.status = hstat_r;
      default:            result.status = jssc_pkg::ST_INVALID;
    endcase
    result.vtype = (result.status == jssc_pkg::ST_OK) ? htype_r : jssc_pkg::TY_NULL;
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    pos_nxt   = pos_r;
    hstat_nxt = hstat_r;
    htype_nxt = htype_r;
    if (ch == jssc_pkg::CH_TERM) begin
      phase_nxt = jssc_pkg::PH_LEAD;
      kind_nxt  = jssc_pkg::LIT_NULL;
      pos_nxt   = 3'd0;
      hstat_nxt = jssc_pkg::ST_OK;
      htype_nxt = jssc_pkg::TY_NULL;
    end else begin
      case (phase_r)
        jssc_pkg::PH_LEAD: begin
          if (jssc_pkg::is_ws(ch)) begin
            phase_nxt = phase_r;
          end else if (ch == "n" || ch == "f" || ch == "t") begin
            kind_nxt  = (ch == "n") ? jssc_pkg::LIT_NULL :
                        (ch == "f") ? jssc_pkg::LIT_FALSE : jssc_pkg::LIT_TRUE;
            pos_nxt   = 3'd1;
            phase_nxt = jssc_pkg::PH_LIT;
          end else if (ch == "-") begin
            phase_nxt = jssc_pkg::PH_SIGN;
          end else if (ch == "0") begin
            htype_nxt = jssc_pkg::TY_NUMBER;
            phase_nxt = jssc_pkg::PH_ZERO;
          end else if (jssc_pkg::is_digit(ch)) begin
            htype_nxt = jssc_pkg::TY_NUMBER;
            phase_nxt = jssc_pkg::PH_INT;
          end else begin
            hstat_nxt = jssc_pkg::ST_INVALID;
            htype_nxt = jssc_pkg::TY_NULL;
            phase_nxt = jssc_pkg::PH_ERR;
          end
        end
        jssc_pkg::PH_LIT: begin
          if (ch != jssc_pkg::lit_char(k, p)) begin
            hstat_nxt = jssc_pkg::ST_INVALID;
            htype_nxt = jssc_pkg::TY_NULL;
            phase_nxt = jssc_pkg::PH_ERR;
          end else begin
            pos_nxt = p_inc;
            if (p_inc >= jssc_pkg::lit_len(k)) begin
              htype_nxt = (k == jssc_pkg::LIT_NULL)  ? jssc_pkg::TY_NULL :
                          (k == jssc_pkg::LIT_FALSE) ? jssc_pkg::TY_FALSE :
                                                       jssc_pkg::TY_TRUE;
              phase_nxt = jssc_pkg::PH_TRAIL;
            end
          end
        end
        jssc_pkg::PH_SIGN: begin
          if (ch == "0") begin
            htype_nxt = jssc_pkg::TY_NUMBER;
            phase_nxt = jssc_pkg::PH_ZERO;
          end else if (jssc_pkg::is_digit(ch)) begin
            htype_nxt = jssc_pkg::TY_NUMBER;
            phase_nxt = jssc_pkg::PH_INT;
          end else begin
            hstat_nxt = jssc_pkg::ST_INVALID;
            htype_nxt = jssc_pkg::TY_NULL;
            phase_nxt = jssc_pkg::PH_ERR;
          end
        end
        jssc_pkg::PH_ZERO,
        jssc_pkg::PH_INT,
        jssc_pkg::PH_FRAC,
        jssc_pkg::PH_EXP: begin
          if (jssc_pkg::is_digit(ch) && phase_r != jssc_pkg::PH_ZERO) begin
            phase_nxt = phase_r;
          end else if (ch == "." &&
                       (phase_r == jssc_pkg::PH_ZERO || phase_r == jssc_pkg::PH_INT)) begin
            phase_nxt = jssc_pkg::PH_FRAC_FIRST;
          end else if ((ch == "e" || ch == "E") && phase_r != jssc_pkg::PH_EXP) begin
            phase_nxt = jssc_pkg::PH_EXP_MARK;
          end else if (jssc_pkg::is_ws(ch)) begin
            phase_nxt = jssc_pkg::PH_TRAIL;
          end else begin
            hstat_nxt = jssc_pkg::ST_NOT_SINGULAR;
            htype_nxt = jssc_pkg::TY_NULL;
            phase_nxt = jssc_pkg::PH_ERR;
          end
        end
        jssc_pkg::PH_FRAC_FIRST,
        jssc_pkg::PH_EXP_FIRST: begin
          if (jssc_pkg::is_digit(ch)) begin
            phase_nxt = (phase_r == jssc_pkg::PH_FRAC_FIRST) ? jssc_pkg::PH_FRAC
                                                             : jssc_pkg::PH_EXP;
          end else begin
            hstat_nxt = jssc_pkg::ST_INVALID;
            htype_nxt = jssc_pkg::TY_NULL;
            phase_nxt = jssc_pkg::PH_ERR;
          end
        end
        jssc_pkg::PH_EXP_MARK: begin
          if (ch == "+" || ch == "-") begin
            phase_nxt = jssc_pkg::PH_EXP_FIRST;
          end else if (jssc_pkg::is_digit(ch)) begin
            phase_nxt = jssc_pkg::PH_EXP;
          end else begin
            hstat_nxt = jssc_pkg::ST_INVALID;
            htype_nxt = jssc_pkg::TY_NULL;
            phase_nxt = jssc_pkg::PH_ERR;
          end
        end
        jssc_pkg::PH_TRAIL: begin
          if (!jssc_pkg::is_ws(ch)) begin
            hstat_nxt = jssc_pkg::ST_NOT_SINGULAR;
            htype_nxt = jssc_pkg::TY_NULL;
            phase_nxt = jssc_pkg::PH_ERR;
          end
        end
        jssc_pkg::PH_ERR: begin
          phase_nxt = phase_r;
        end
        default: begin
          hstat_nxt = jssc_pkg::ST_INVALID;
          htype_nxt = jssc_pkg::TY_NULL;
          phase_nxt = jssc_pkg::PH_ERR;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jssc_pkg::PH_LEAD;
      kind_r  <= jssc_pkg::LIT_NULL;
      pos_r   <= 3'd0;
      hstat_r <= jssc_pkg::ST_OK;
      htype_r <= jssc_pkg::TY_NULL;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      pos_r   <= pos_nxt;
      hstat_r <= hstat_nxt;
      htype_r <= htype_nxt;
    end
  end

endmodule

/* hw/rtl/json_scalar_syntax_checker_unit.sv */
// Channel | Dir | Ports                     | Payload
// in      | in  | in_tvalid/tready/tdata    | tdata[7:0] ch
// out     | out | out_tvalid/tready/tdata   | tdata[1:0] status, [3:2] value_type, [7:4] 0
//
// One byte per cycle sustained while no terminator is stalled: a byte waits in the input
// register, then the parser state updates; a terminator's result is loaded into the output
// register in the same cycle as that parser update.
// rst_n is synchronous, active low, and returns the parser to leading whitespace.
// A waiting result stalls only a following terminator; other bytes keep flowing.
module json_scalar_syntax_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] status, [3:2] value_type, [7:4] zero
);

  logic                 in_valid_r;
  logic [7:0]           in_ch_r;
  logic                 is_term;
  logic                 out_free;
  logic                 step;
  jssc_pkg::result_t    result;
  jssc_pkg::phase_t     phase;
  logic                 out_valid_r;
  jssc_pkg::result_t    out_res_r;

  assign is_term   = (in_ch_r == jssc_pkg::CH_TERM);
  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && (!is_term || out_free);
  assign in_tready = !in_valid_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ch_r <= in_tdata;
    end
  end

  jssc_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .ch     (in_ch_r),
    .result (result),
    .phase  (phase)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && is_term;
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_term) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.vtype, out_res_r.status};

  // checks
  a_err_type_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == jssc_pkg::ST_OK || out_tdata[3:2] == jssc_pkg::TY_NULL))
    else $error("error result with non-null type");

  a_term_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_term) |=> (phase == jssc_pkg::PH_LEAD))
    else $error("parser not back in leading phase after terminator");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && is_term && out_valid_r && !out_tready))
    else $error("input stalled without a blocked terminator");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_term) |=> out_tvalid)
    else $error("terminator consumed without a result");

endmodule

/* verif/json_scalar_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the syntax checker. It keeps a shadow parser
// that is stepped on every accepted input beat. A terminator queues the
// status/type pair that the parser should report. Every result beat is
// matched against the oldest queued pair.
module json_scalar_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] ch
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,   // [1:0] status, [3:2] value_type, [7:4] zero
  output int         fail_count,
  output int         pending,
  output int         results_seen
);

  // Shadow parser state
  jssc_pkg::phase_t  ph;
  logic [1:0]        lit_k;
  logic [2:0]        lit_p;
  jssc_pkg::status_t held_st;
  jssc_pkg::vtype_t  held_ty;

  // Results owed by the block, oldest first
  jssc_pkg::result_t verdict_q[$];

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Byte p of literal k; out-of-range selectors fall back as the block does
  function automatic logic [7:0] literal_byte(input logic [1:0] k, input logic [2:0] p);
    logic [39:0] word;
    int          idx;
    if (k == jssc_pkg::LIT_FALSE) word = "false";
    else if (k == jssc_pkg::LIT_TRUE) word = {"true", 8'h00};
    else word = {"null", 8'h00};
    idx = (p > 3'd4) ? 4 : int'(p);
    return word[39 - 8 * idx -: 8];
  endfunction

  task automatic clear_parser();
    ph      = jssc_pkg::PH_LEAD;
    lit_k   = jssc_pkg::LIT_NULL;
    lit_p   = 3'd0;
    held_st = jssc_pkg::ST_OK;
    held_ty = jssc_pkg::TY_NULL;
  endtask

  task automatic latch_error(input jssc_pkg::status_t code);
    held_st = code;
    held_ty = jssc_pkg::TY_NULL;
    ph      = jssc_pkg::PH_ERR;
  endtask

  // Byte after a complete value: only whitespace may follow
  task automatic after_value(input logic [7:0] c);
    ph = jssc_pkg::PH_TRAIL;
    if (!is_blank(c)) latch_error(jssc_pkg::ST_NOT_SINGULAR);
  endtask

  task automatic step_parser(input logic [7:0] c);
    jssc_pkg::result_t r;
    logic [2:0]        p;
    logic [2:0]        len;
    if (c == jssc_pkg::CH_TERM) begin
      case (ph)
        jssc_pkg::PH_LEAD: r.status = jssc_pkg::ST_EXPECT;
        jssc_pkg::PH_ZERO, jssc_pkg::PH_INT, jssc_pkg::PH_FRAC,
        jssc_pkg::PH_EXP, jssc_pkg::PH_TRAIL: r.status = jssc_pkg::ST_OK;
        jssc_pkg::PH_ERR: r.status = held_st;
        default: r.status = jssc_pkg::ST_INVALID;
      endcase
      r.vtype = (r.status == jssc_pkg::ST_OK) ? held_ty : jssc_pkg::TY_NULL;
      verdict_q.push_back(r);
      clear_parser();
    end else begin
      case (ph)
        jssc_pkg::PH_LEAD: begin
          if (is_blank(c)) begin
          end else if (c == "n" || c == "f" || c == "t") begin
            lit_k = (c == "n") ? jssc_pkg::LIT_NULL :
                    ((c == "f") ? jssc_pkg::LIT_FALSE : jssc_pkg::LIT_TRUE);
            lit_p = 3'd1;
            ph    = jssc_pkg::PH_LIT;
          end else if (c == "-") begin
            ph = jssc_pkg::PH_SIGN;
          end else if (c == "0") begin
            held_ty = jssc_pkg::TY_NUMBER;
            ph      = jssc_pkg::PH_ZERO;
          end else if (is_dec(c)) begin
            held_ty = jssc_pkg::TY_NUMBER;
            ph      = jssc_pkg::PH_INT;
          end else begin
            latch_error(jssc_pkg::ST_INVALID);
          end
        end
        jssc_pkg::PH_LIT: begin
          p   = (lit_p > 3'd4) ? 3'd4 : lit_p;
          len = (lit_k == jssc_pkg::LIT_FALSE) ? 3'd5 : 3'd4;
          if (c != literal_byte(lit_k, p)) begin
            latch_error(jssc_pkg::ST_INVALID);
          end else begin
            lit_p = p + 3'd1;
            if (lit_p >= len) begin
              if (lit_k == jssc_pkg::LIT_FALSE) held_ty = jssc_pkg::TY_FALSE;
              else if (lit_k == jssc_pkg::LIT_TRUE) held_ty = jssc_pkg::TY_TRUE;
              else held_ty = jssc_pkg::TY_NULL;
              ph = jssc_pkg::PH_TRAIL;
            end
          end
        end
        jssc_pkg::PH_SIGN: begin
          if (c == "0") begin
            held_ty = jssc_pkg::TY_NUMBER;
            ph      = jssc_pkg::PH_ZERO;
          end else if (is_dec(c)) begin
            held_ty = jssc_pkg::TY_NUMBER;
            ph      = jssc_pkg::PH_INT;
          end else begin
            latch_error(jssc_pkg::ST_INVALID);
          end
        end
        jssc_pkg::PH_ZERO, jssc_pkg::PH_INT: begin
          if (ph == jssc_pkg::PH_INT && is_dec(c)) begin
          end else if (c == ".") begin
            ph = jssc_pkg::PH_FRAC_FIRST;
          end else if (c == "e" || c == "E") begin
            ph = jssc_pkg::PH_EXP_MARK;
          end else begin
            after_value(c);
          end
        end
        jssc_pkg::PH_FRAC_FIRST: begin
          if (is_dec(c)) ph = jssc_pkg::PH_FRAC;
          else latch_error(jssc_pkg::ST_INVALID);
        end
        jssc_pkg::PH_FRAC: begin
          if (is_dec(c)) begin
          end else if (c == "e" || c == "E") begin
            ph = jssc_pkg::PH_EXP_MARK;
          end else begin
            after_value(c);
          end
        end
        jssc_pkg::PH_EXP_MARK: begin
          if (c == "+" || c == "-") ph = jssc_pkg::PH_EXP_FIRST;
          else if (is_dec(c)) ph = jssc_pkg::PH_EXP;
          else latch_error(jssc_pkg::ST_INVALID);
        end
        jssc_pkg::PH_EXP_FIRST: begin
          if (is_dec(c)) ph = jssc_pkg::PH_EXP;
          else latch_error(jssc_pkg::ST_INVALID);
        end
        jssc_pkg::PH_EXP: begin
          if (!is_dec(c)) after_value(c);
        end
        jssc_pkg::PH_TRAIL: after_value(c);
        jssc_pkg::PH_ERR: begin
        end
        default: latch_error(jssc_pkg::ST_INVALID);
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(input logic [7:0] d);
    jssc_pkg::result_t want;
    results_seen++;
    if (verdict_q.size() == 0) begin
      report_mismatch("unexpected result beat", int'(d), 0);
    end else begin
      want = verdict_q.pop_front();
      if (d[1:0] != want.status)
        report_mismatch("status", int'(d[1:0]), int'(want.status));
      if (d[3:2] != want.vtype)
        report_mismatch("value_type", int'(d[3:2]), int'(want.vtype));
      if (d[7:4] != 4'd0) report_mismatch("pad bits", int'(d[7:4]), 0);
    end
  endtask

  // Output beat first so a result can never match the terminator of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      verdict_q.delete();
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) step_parser(in_tdata);
      pending = verdict_q.size();
    end
  end

endmodule

/* verif/json_scalar_syntax_checker_unit_tb.sv */
`timescale 1ns / 1ps

module json_scalar_syntax_checker_unit_tb;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  int fail_count;
  int pending;
  int results_seen;

  int bytes_sent = 0;
  int texts_sent = 0;
  bit calm_in    = 1'b0;
  bit calm_out   = 1'b0;

  logic [7:0] text_q[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  json_scalar_syntax_checker_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  json_scalar_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // One input beat; valid stays high across back-to-back beats
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // Send the built text followed by its terminator
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i]);
    send_byte(jssc_pkg::CH_TERM);
    texts_sent++;
  endtask

  task automatic push_word(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic push_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) text_q.push_back(8'("0" + $urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return 8'h09;
      2: return 8'h0a;
      default: return 8'h0d;
    endcase
  endfunction

  // Bytes that steer the parser somewhere interesting, or anything at all
  function automatic logic [7:0] pick_tricky();
    string s;
    s = "0123456789.eE+-nultrfas x";
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(1, 255));
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Mostly well-formed values with random content, some broken, some noise
  task automatic build_random_text();
    int kind;
    int pos;
    text_q.delete();
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) text_q.push_back(pick_blank());
      if (kind >= 2 && kind <= 4) begin
        case ($urandom_range(0, 2))
          0: push_word("null");
          1: push_word("false");
          default: push_word("true");
        endcase
      end else if (kind >= 5) begin
        if ($urandom_range(0, 2) == 0) text_q.push_back("-");
        if ($urandom_range(0, 2) == 0) begin
          text_q.push_back("0");
        end else begin
          text_q.push_back(8'("0" + $urandom_range(1, 9)));
          push_digits(0, 3);
        end
        if ($urandom_range(0, 1) == 0) begin
          text_q.push_back(".");
          push_digits(1, 3);
        end
        if ($urandom_range(0, 2) == 0) begin
          text_q.push_back($urandom_range(0, 1) ? "e" : "E");
          case ($urandom_range(0, 2))
            0: text_q.push_back("+");
            1: text_q.push_back("-");
            default: ;
          endcase
          push_digits(1, 2);
        end
      end
      repeat ($urandom_range(0, 2)) text_q.push_back(pick_blank());
      // Damage about one text in four
      if (text_q.size() > 0 && $urandom_range(0, 3) == 0) begin
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 2))
          0: text_q[pos] = pick_tricky();
          1: while (text_q.size() > pos) void'(text_q.pop_back());
          default: text_q.insert(pos, pick_tricky());
        endcase
      end
    end
  endtask

  // Result side: random stall before each result, with calm stretches
  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm_out = !calm_out;
      stall = calm_out ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty text, a literal, a literal cut short, a lone minus,
    // leading zero, extra bytes after a value, bytes after a latched error
    text_q.delete();
    send_text();
    text_q.delete(); push_word("true"); send_text();
    text_q.delete(); push_word("fals"); send_text();
    text_q.delete(); push_word("-"); send_text();
    text_q.delete(); push_word("01"); send_text();
    text_q.delete(); push_word("1 x"); send_text();
    text_q.delete(); text_q.push_back(8'hff); text_q.push_back(8'h80); send_text();

    // Random texts
    while (bytes_sent < 650) begin
      build_random_text();
      send_text();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d texts (literals, numbers, noise, damaged values)",
             bytes_sent, texts_sent);
    $display("Checked %0d result beats, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* json_scalar_syntax_checker_unit.f */
hw/rtl/jssc_pkg.sv
hw/rtl/jssc_parse.sv
hw/rtl/json_scalar_syntax_checker_unit.sv
verif/json_scalar_checker.sv
verif/json_scalar_syntax_checker_unit_tb.sv
